// ----- hdl/cmbs_pkg.sv -----
// Package: types, codes and wait constants shared by the modem bring-up sequencer.
`default_nettype none
package cmbs_pkg;

  typedef enum logic [3:0] {
    ST_OFF       = 4'd0,
    ST_INIT      = 4'd1,
    ST_RESET     = 4'd2,
    ST_READY     = 4'd3,
    ST_SIM       = 4'd4,
    ST_BAUD      = 4'd5,
    ST_MODE      = 4'd6,
    ST_WAITMODE  = 4'd7,
    ST_SIGNAL    = 4'd8,
    ST_ATTACH    = 4'd9,
    ST_LINKED    = 4'd10,
    ST_HANDSHAKE = 4'd11,
    ST_FIRST     = 4'd12,
    ST_CONNECTED = 4'd13,
    ST_ERROR     = 4'd14
  } state_t;

  typedef enum logic [1:0] {
    WK_TIMED = 2'd0,
    WK_NOW   = 2'd1,
    WK_NEVER = 2'd2
  } wait_kind_t;

  typedef enum logic [1:0] {
    CFG_NB_MODE           = 2'd0,
    CFG_BROKER_CONFIGURED = 2'd1,
    CFG_SIM_RETRY_LIMIT   = 2'd2,
    CFG_LINK_RETRY_LIMIT  = 2'd3
  } cfg_index_t;

  localparam int CfgDataWidth = 3;

  localparam logic [6:0] SQ_UNKNOWN = 7'd99;
  localparam logic signed [7:0] SIGNAL_NONE = -8'sd1;

  localparam logic [15:0] MS_500   = 16'd500;
  localparam logic [15:0] MS_1000  = 16'd1000;
  localparam logic [15:0] MS_1500  = 16'd1500;
  localparam logic [15:0] MS_2000  = 16'd2000;
  localparam logic [15:0] MS_3000  = 16'd3000;
  localparam logic [15:0] MS_4000  = 16'd4000;
  localparam logic [15:0] MS_5000  = 16'd5000;
  localparam logic [15:0] MS_7000  = 16'd7000;
  localparam logic [15:0] MS_10000 = 16'd10000;
  localparam logic [15:0] MS_15000 = 16'd15000;
  localparam logic [15:0] MS_30000 = 16'd30000;
  localparam logic [15:0] MS_60000 = 16'd60000;

  typedef struct packed {
    logic       nb_mode;
    logic       broker_configured;
    logic [2:0] sim_retry_limit;
    logic [2:0] link_retry_limit;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic       cmd_ok;
    logic [6:0] signal_quality;
    logic       pending_messages;
  } item_t;

  typedef struct packed {
    state_t            next_state;
    wait_kind_t        wait_kind;
    logic [15:0]       wait_ms;
    logic              power_pulse;
    logic              power_down_probe;
    logic              publish_info;
    logic              flush_request;
    logic              restart_request;
    logic signed [7:0] recorded_signal;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/cmbs_if.sv -----
// Interfaces: input event channel and result channel of the sequencer.
`default_nettype none
interface cmbs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic       cmd_ok;
  logic [6:0] signal_quality;
  logic       pending_messages;

  modport source (output valid, action, cmd_ok, signal_quality, pending_messages,
                  input ready);
  modport sink   (input valid, action, cmd_ok, signal_quality, pending_messages,
                  output ready);
endinterface

interface cmbs_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        next_state;
  logic [1:0]        wait_kind;
  logic [15:0]       wait_ms;
  logic              power_pulse;
  logic              power_down_probe;
  logic              publish_info;
  logic              flush_request;
  logic              restart_request;
  logic signed [7:0] recorded_signal;

  modport source (output valid, next_state, wait_kind, wait_ms, power_pulse,
                  power_down_probe, publish_info, flush_request, restart_request,
                  recorded_signal, input ready);
  modport sink   (input valid, next_state, wait_kind, wait_ms, power_pulse,
                  power_down_probe, publish_info, flush_request, restart_request,
                  recorded_signal, output ready);
endinterface
`default_nettype wire

// ----- hdl/cmbs_step.sv -----
// Next-state logic: one transition of the bring-up machine for one event.
`default_nettype none
module cmbs_step (
  input  cmbs_pkg::cfg_t            cfg,
  input  cmbs_pkg::item_t           item,
  input  cmbs_pkg::state_t          state,
  input  logic [2:0]                retry,
  input  logic signed [7:0]         last_signal,
  output cmbs_pkg::result_t         res,
  output logic [2:0]                retry_next
);
  import cmbs_pkg::*;

  logic [2:0]  bumped;
  logic [15:0] mode_wait;
  logic        signal_good;

  assign bumped      = retry + 3'd1;   // wraps modulo 8
  assign mode_wait   = cfg.nb_mode ? MS_2000 : MS_1000;
  assign signal_good = (item.signal_quality != 7'd0) && (item.signal_quality < SQ_UNKNOWN);

  always_comb begin
    res                  = '0;
    res.next_state       = state;
    res.wait_kind        = WK_TIMED;
    res.wait_ms          = '0;
    res.recorded_signal  = last_signal;
    retry_next           = retry;

    if (item.action) begin
      res.next_state = ST_INIT;
      res.wait_kind  = WK_NOW;
    end else begin
      unique case (state)
        ST_INIT: begin
          res.power_down_probe = item.cmd_ok;
          res.next_state = ST_RESET;
          res.wait_ms    = MS_4000;
        end
        ST_RESET: begin
          res.power_pulse = 1'b1;
          res.next_state  = ST_READY;
          res.wait_ms     = MS_7000;
        end
        ST_READY: begin
          if (item.cmd_ok) begin
            res.next_state = ST_SIM;
            retry_next     = '0;
            res.wait_kind  = WK_NOW;
          end else begin
            res.power_pulse = 1'b1;
            res.wait_ms     = MS_5000;
          end
        end
        ST_SIM: begin
          if (item.cmd_ok) begin
            res.next_state = ST_BAUD;
            retry_next     = '0;
            res.wait_kind  = WK_NOW;
          end else if (bumped >= cfg.sim_retry_limit) begin
            res.next_state = ST_ERROR;
            retry_next     = '0;
            res.wait_ms    = MS_30000;
          end else begin
            retry_next  = bumped;
            res.wait_ms = MS_2000;
          end
        end
        ST_BAUD: begin
          if (item.cmd_ok) begin
            res.next_state = ST_MODE;
            res.wait_kind  = WK_NOW;
          end else begin
            res.next_state = ST_READY;
            res.wait_ms    = MS_1000;
          end
        end
        ST_MODE: begin
          if (item.cmd_ok) begin
            res.next_state = ST_WAITMODE;
            res.wait_ms    = mode_wait;
          end else begin
            res.next_state = ST_READY;
            res.wait_ms    = MS_30000;
          end
        end
        ST_WAITMODE: begin
          res.next_state = ST_SIGNAL;
          retry_next     = '0;
          res.wait_ms    = MS_1500;
        end
        ST_SIGNAL: begin
          res.recorded_signal = {1'b0, item.signal_quality};
          if (signal_good) begin
            res.next_state = ST_ATTACH;
            retry_next     = '0;
            res.wait_ms    = MS_500;
          end else if (bumped >= cfg.link_retry_limit) begin
            res.next_state = ST_READY;
            retry_next     = '0;
            res.wait_ms    = MS_30000;
          end else begin
            retry_next  = bumped;
            res.wait_ms = MS_3000;
          end
        end
        ST_ATTACH: begin
          if (item.cmd_ok) begin
            res.next_state = ST_LINKED;
            retry_next     = '0;
            res.wait_ms    = mode_wait;
          end else if (bumped >= cfg.link_retry_limit) begin
            res.next_state = ST_READY;
            retry_next     = '0;
            res.wait_ms    = MS_30000;
          end else begin
            retry_next  = bumped;
            res.wait_ms = MS_3000;
          end
        end
        ST_LINKED: begin
          if (!cfg.broker_configured) begin
            res.wait_kind = WK_NEVER;
          end else if (item.cmd_ok) begin
            res.next_state = ST_HANDSHAKE;
            res.wait_ms    = MS_1000;
          end else begin
            res.wait_ms = MS_10000;
          end
        end
        ST_HANDSHAKE: begin
          if (item.cmd_ok) begin
            res.next_state = ST_FIRST;
            res.wait_ms    = MS_500;
          end else begin
            res.next_state = ST_LINKED;
            res.wait_ms    = MS_10000;
          end
        end
        ST_FIRST: begin
          res.publish_info = 1'b1;
          res.next_state   = ST_CONNECTED;
          res.wait_kind    = WK_NOW;
        end
        ST_CONNECTED: begin
          res.flush_request = item.pending_messages;
          res.wait_ms       = MS_15000;
        end
        ST_ERROR: begin
          res.restart_request = 1'b1;
          if (item.cmd_ok) begin
            res.next_state = ST_READY;
            res.wait_ms    = MS_5000;
          end else begin
            res.wait_ms = MS_60000;
          end
        end
        default: begin
          // off, or the spare code: hold and poll slowly
          res.wait_ms = MS_10000;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cellular_modem_bringup_sequencer_unit.sv -----
// Top level: modem bring-up sequencer with registered input and result stages.
//
//  channel  dir  handshake            payload
//  item     in   item.valid/ready     action, cmd_ok, signal_quality, pending_messages
//  result   out  result.valid/ready   next_state, wait_kind, wait_ms, strobes,
//                                     recorded_signal
//  cfg      in   cfg_we (no stall)    cfg_index, cfg_data
//
// One transfer in, one transfer out; each event passes through the input register and
// then the transition logic into the result register. A new event
// may be taken every cycle: the machine state, retry count and signal reading are
// updated at the same edge as the result register, so the next event sees them.
// Reset (rst, synchronous) puts the machine off, clears the retry count, marks the
// signal as never read and loads the register defaults. When the result is stalled
// the input register holds and item.ready drops only if both stages are full.
`default_nettype none
module cellular_modem_bringup_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst,
  cmbs_in_if.sink                           item,
  cmbs_out_if.source                        result,
  input  logic                              cfg_we,
  input  cmbs_pkg::cfg_index_t              cfg_index,
  input  logic [cmbs_pkg::CfgDataWidth-1:0] cfg_data
);
  import cmbs_pkg::*;

  // configuration
  cfg_t cfg;

  // input stage
  logic  s1_valid;
  item_t s1_item;

  // machine state
  state_t            state;
  logic [2:0]        retry;
  logic signed [7:0] last_signal;

  // result stage
  logic    out_valid;
  result_t out_res;

  result_t step_res;
  logic [2:0] retry_next;
  logic s2_load;
  logic s1_load;

  assign s2_load    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s2_load;
  assign s1_load    = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nb_mode           <= 1'b1;
      cfg.broker_configured <= 1'b0;
      cfg.sim_retry_limit   <= 3'd3;
      cfg.link_retry_limit  <= 3'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NB_MODE:           cfg.nb_mode           <= cfg_data[0];
        CFG_BROKER_CONFIGURED: cfg.broker_configured <= cfg_data[0];
        CFG_SIM_RETRY_LIMIT:   cfg.sim_retry_limit   <= cfg_data[2:0];
        CFG_LINK_RETRY_LIMIT:  cfg.link_retry_limit  <= cfg_data[2:0];
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item.action           <= item.action;
      s1_item.cmd_ok           <= item.cmd_ok;
      s1_item.signal_quality   <= item.signal_quality;
      s1_item.pending_messages <= item.pending_messages;
    end
  end

  cmbs_step u_step (
    .cfg         (cfg),
    .item        (s1_item),
    .state       (state),
    .retry       (retry),
    .last_signal (last_signal),
    .res         (step_res),
    .retry_next  (retry_next)
  );

  // machine state moves with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_OFF;
      retry       <= '0;
      last_signal <= SIGNAL_NONE;
    end else if (s2_load) begin
      state       <= step_res.next_state;
      retry       <= retry_next;
      last_signal <= step_res.recorded_signal;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_res <= step_res;
    end
  end

  assign result.valid            = out_valid;
  assign result.next_state       = out_res.next_state;
  assign result.wait_kind        = out_res.wait_kind;
  assign result.wait_ms          = out_res.wait_ms;
  assign result.power_pulse      = out_res.power_pulse;
  assign result.power_down_probe = out_res.power_down_probe;
  assign result.publish_info     = out_res.publish_info;
  assign result.flush_request    = out_res.flush_request;
  assign result.restart_request  = out_res.restart_request;
  assign result.recorded_signal  = out_res.recorded_signal;

  // a timed wait is the only kind that carries a duration
  a_wait_ms_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.wait_kind != WK_TIMED) |-> (out_res.wait_ms == 16'd0))
    else $error("wait_ms set on an untimed wait");

  // input stalls only with both stages full and the result held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> s1_valid && out_valid && !result.ready)
    else $error("input stalled with room in the pipeline");

  // a transition always lands in the result register
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> out_valid)
    else $error("result lost after transition");

  // machine state changes only with a transition
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s2_load |=> $stable(state) && $stable(retry) && $stable(last_signal))
    else $error("machine state moved without a transition");

endmodule
`default_nettype wire

// ----- dv/cmbs_transition_checker.sv -----
// Checker for the modem bring-up sequencer: watches both channels, predicts, compares.
`timescale 1ns / 100ps
module cmbs_transition_checker (
  input  logic                              clk,
  input  logic                              rst,
  cmbs_in_if                                item,
  cmbs_out_if                               result,
  input  logic                              cfg_we,
  input  cmbs_pkg::cfg_index_t              cfg_index,
  input  logic [cmbs_pkg::CfgDataWidth-1:0] cfg_data,
  output int                                fail_count,
  output int                                outstanding
);
  import cmbs_pkg::*;

  cfg_t              settings;
  state_t            mstate;
  logic [2:0]        retries;
  logic signed [7:0] last_reading;

  result_t pending_transitions[$];
  result_t seen, want;
  item_t   ev;
  int      failures;
  int      reported;

  // bump the retry count (wraps at 8), true once the limit is reached
  function automatic logic retry_exhausted(logic [2:0] limit);
    retries = retries + 3'd1;
    return retries >= limit;
  endfunction

  function automatic result_t predict_transition(item_t e);
    result_t     r;
    state_t      st;
    logic [15:0] mode_wait;
    r         = '0;
    st        = mstate;
    mode_wait = settings.nb_mode ? MS_2000 : MS_1000;
    if (e.action) begin
      st          = ST_INIT;
      r.wait_kind = WK_NOW;
    end else begin
      case (mstate)
        ST_INIT: begin
          r.power_down_probe = e.cmd_ok;
          st = ST_RESET; r.wait_ms = MS_4000;
        end
        ST_RESET: begin
          r.power_pulse = 1'b1;
          st = ST_READY; r.wait_ms = MS_7000;
        end
        ST_READY: begin
          if (e.cmd_ok) begin
            st = ST_SIM; retries = '0; r.wait_kind = WK_NOW;
          end else begin
            r.power_pulse = 1'b1; r.wait_ms = MS_5000;
          end
        end
        ST_SIM: begin
          if (e.cmd_ok) begin
            st = ST_BAUD; retries = '0; r.wait_kind = WK_NOW;
          end else if (retry_exhausted(settings.sim_retry_limit)) begin
            st = ST_ERROR; retries = '0; r.wait_ms = MS_30000;
          end else begin
            r.wait_ms = MS_2000;
          end
        end
        ST_BAUD: begin
          if (e.cmd_ok) begin
            st = ST_MODE; r.wait_kind = WK_NOW;
          end else begin
            st = ST_READY; r.wait_ms = MS_1000;
          end
        end
        ST_MODE: begin
          if (e.cmd_ok) begin
            st = ST_WAITMODE; r.wait_ms = mode_wait;
          end else begin
            st = ST_READY; r.wait_ms = MS_30000;
          end
        end
        ST_WAITMODE: begin
          st = ST_SIGNAL; retries = '0; r.wait_ms = MS_1500;
        end
        ST_SIGNAL: begin
          last_reading = {1'b0, e.signal_quality};
          if (e.signal_quality != 7'd0 && e.signal_quality < SQ_UNKNOWN) begin
            st = ST_ATTACH; retries = '0; r.wait_ms = MS_500;
          end else if (retry_exhausted(settings.link_retry_limit)) begin
            st = ST_READY; retries = '0; r.wait_ms = MS_30000;
          end else begin
            r.wait_ms = MS_3000;
          end
        end
        ST_ATTACH: begin
          if (e.cmd_ok) begin
            st = ST_LINKED; retries = '0; r.wait_ms = mode_wait;
          end else if (retry_exhausted(settings.link_retry_limit)) begin
            st = ST_READY; retries = '0; r.wait_ms = MS_30000;
          end else begin
            r.wait_ms = MS_3000;
          end
        end
        ST_LINKED: begin
          if (!settings.broker_configured) begin
            r.wait_kind = WK_NEVER;
          end else if (e.cmd_ok) begin
            st = ST_HANDSHAKE; r.wait_ms = MS_1000;
          end else begin
            r.wait_ms = MS_10000;
          end
        end
        ST_HANDSHAKE: begin
          if (e.cmd_ok) begin
            st = ST_FIRST; r.wait_ms = MS_500;
          end else begin
            st = ST_LINKED; r.wait_ms = MS_10000;
          end
        end
        ST_FIRST: begin
          r.publish_info = 1'b1;
          st = ST_CONNECTED; r.wait_kind = WK_NOW;
        end
        ST_CONNECTED: begin
          r.flush_request = e.pending_messages;
          r.wait_ms = MS_15000;
        end
        ST_ERROR: begin
          r.restart_request = 1'b1;
          if (e.cmd_ok) begin
            st = ST_READY; r.wait_ms = MS_5000;
          end else begin
            r.wait_ms = MS_60000;
          end
        end
        default: begin
          r.wait_ms = MS_10000;
        end
      endcase
    end
    mstate            = st;
    r.next_state      = st;
    r.recorded_signal = last_reading;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settings.nb_mode           = 1'b1;
      settings.broker_configured = 1'b0;
      settings.sim_retry_limit   = 3'd3;
      settings.link_retry_limit  = 3'd5;
      mstate       = ST_OFF;
      retries      = '0;
      last_reading = SIGNAL_NONE;
      pending_transitions.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NB_MODE:           settings.nb_mode = cfg_data[0];
          CFG_BROKER_CONFIGURED: settings.broker_configured = cfg_data[0];
          CFG_SIM_RETRY_LIMIT:   settings.sim_retry_limit = cfg_data[2:0];
          CFG_LINK_RETRY_LIMIT:  settings.link_retry_limit = cfg_data[2:0];
          default: ;
        endcase
      end
      // retire the output transfer first so a result can never match its own event
      if (result.valid && result.ready) begin
        seen.next_state       = state_t'(result.next_state);
        seen.wait_kind        = wait_kind_t'(result.wait_kind);
        seen.wait_ms          = result.wait_ms;
        seen.power_pulse      = result.power_pulse;
        seen.power_down_probe = result.power_down_probe;
        seen.publish_info     = result.publish_info;
        seen.flush_request    = result.flush_request;
        seen.restart_request  = result.restart_request;
        seen.recorded_signal  = result.recorded_signal;
        if (pending_transitions.size() == 0) begin
          failures++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result, state %0d", $realtime, seen.next_state);
          end
        end else begin
          want = pending_transitions.pop_front();
          if (seen !== want) begin
            failures++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch exp st %0d wk %0d ms %0d strb %b sig %0d",
                       $realtime, want.next_state, want.wait_kind, want.wait_ms,
                       {want.power_pulse, want.power_down_probe, want.publish_info,
                        want.flush_request, want.restart_request}, want.recorded_signal);
              $display("%0t:          got st %0d wk %0d ms %0d strb %b sig %0d",
                       $realtime, seen.next_state, seen.wait_kind, seen.wait_ms,
                       {seen.power_pulse, seen.power_down_probe, seen.publish_info,
                        seen.flush_request, seen.restart_request}, seen.recorded_signal);
            end
          end
        end
      end
      if (item.valid && item.ready) begin
        ev.action           = item.action;
        ev.cmd_ok           = item.cmd_ok;
        ev.signal_quality   = item.signal_quality;
        ev.pending_messages = item.pending_messages;
        pending_transitions.push_back(predict_transition(ev));
      end
    end
    outstanding <= pending_transitions.size();
    fail_count  <= failures;
  end

endmodule

// ----- dv/cellular_modem_bringup_sequencer_unit_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the modem bring-up sequencer.
`timescale 1ns / 100ps
module cellular_modem_bringup_sequencer_unit_tb;
  import cmbs_pkg::*;

  localparam int HOLD_OFF_CYCLES = 200;    // long receiver stall, fills both stages
  localparam int SETTLE_CYCLES   = 4;      // two-stage pipe, plus margin
  localparam int CYCLE_LIMIT     = 400000; // far above the slowest legal run
  localparam int NUM_PHASES      = 6;
  localparam int PHASE_EVENTS    = 280;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  cfg_index_t              cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  int   fail_count;
  int   outstanding;
  int   cycles;
  bit   calm;          // no idling on either side
  bit   hold_off_req;  // asks the receiver for one long stall
  cfg_t phase_cfg [0:NUM_PHASES-1];

  cmbs_in_if  ev_ch ();
  cmbs_out_if res_ch ();

  cellular_modem_bringup_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .item      (ev_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cmbs_transition_checker chk (
    .clk         (clk),
    .rst         (rst),
    .item        (ev_ch),
    .result      (res_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cellular_modem_bringup_sequencer_unit_tb: errors");
      $finish;
    end
  end

  function automatic item_t make_event(logic act, logic ok, logic [6:0] sq, logic pend);
    item_t e;
    e.action           = act;
    e.cmd_ok           = ok;
    e.signal_quality   = sq;
    e.pending_messages = pend;
    return e;
  endfunction

  // Mostly well-formed ticks: the command usually succeeds and the reading is
  // usually usable, so the machine climbs deep. Occasional initialise events
  // restart it from the terminal states (connected, linked without broker).
  function automatic item_t random_event(int ok_pct);
    item_t e;
    e.action = ($urandom_range(0, 99) < 4);
    e.cmd_ok = ($urandom_range(0, 99) < ok_pct);
    if ($urandom_range(0, 9) < 7)
      e.signal_quality = 7'($urandom_range(1, 98));
    else if ($urandom_range(0, 2) == 0)
      e.signal_quality = 7'd0;
    else
      e.signal_quality = 7'($urandom_range(99, 127));
    e.pending_messages = 1'($urandom_range(0, 1));
    return e;
  endfunction

  // One transfer on the event channel, then perhaps a gap with valid low.
  task automatic offer(input item_t e);
    ev_ch.valid            <= 1'b1;
    ev_ch.action           <= e.action;
    ev_ch.cmd_ok           <= e.cmd_ok;
    ev_ch.signal_quality   <= e.signal_quality;
    ev_ch.pending_messages <= e.pending_messages;
    do @(posedge clk); while (!ev_ch.ready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      ev_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Block goes idle once every predicted transition has come out; one result
  // per event, so nothing can still be in flight after that bar the settle.
  task automatic drain();
    ev_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All four registers back to back, write enable held high throughout.
  task automatic apply_settings(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NB_MODE;
    cfg_data  <= CfgDataWidth'(c.nb_mode);
    @(posedge clk);
    cfg_index <= CFG_BROKER_CONFIGURED;
    cfg_data  <= CfgDataWidth'(c.broker_configured);
    @(posedge clk);
    cfg_index <= CFG_SIM_RETRY_LIMIT;
    cfg_data  <= c.sim_retry_limit;
    @(posedge clk);
    cfg_index <= CFG_LINK_RETRY_LIMIT;
    cfg_data  <= c.link_retry_limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: ready bursts, random stalls, one long hold-off.
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    calm         = 1'b0;
    hold_off_req = 1'b0;
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_NB_MODE;
    cfg_data               <= '0;
    ev_ch.valid            <= 1'b0;
    ev_ch.action           <= 1'b0;
    ev_ch.cmd_ok           <= 1'b0;
    ev_ch.signal_quality   <= '0;
    ev_ch.pending_messages <= 1'b0;

    // nb, broker, sim limit, link limit; extremes incl. limit of zero
    phase_cfg[0] = '{nb_mode: 1'b0, broker_configured: 1'b1,
                     sim_retry_limit: 3'd7, link_retry_limit: 3'd7};
    phase_cfg[1] = '{nb_mode: 1'b1, broker_configured: 1'b0,
                     sim_retry_limit: 3'd1, link_retry_limit: 3'd1};
    phase_cfg[2] = '{nb_mode: 1'b0, broker_configured: 1'b1,
                     sim_retry_limit: 3'd0, link_retry_limit: 3'd0};
    phase_cfg[3] = '{nb_mode: 1'b1, broker_configured: 1'b1,
                     sim_retry_limit: 3'd2, link_retry_limit: 3'd4};
    phase_cfg[4] = '{nb_mode: 1'b0, broker_configured: 1'b0,
                     sim_retry_limit: 3'd7, link_retry_limit: 3'd1};
    phase_cfg[5] = '{nb_mode: 1'b1, broker_configured: 1'b1,
                     sim_retry_limit: 3'd5, link_retry_limit: 3'd3};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk: tick while off, initialise, every bring-up step, with both
    // outcomes at ready, SIM, attach and linked, readings of zero, unknown and
    // out of range, up to connected with and without buffered messages.
    apply_settings('{nb_mode: 1'b1, broker_configured: 1'b1,
                     sim_retry_limit: 3'd3, link_retry_limit: 3'd5});
    offer(make_event(1'b0, 1'b1, 7'd127, 1'b1)); // tick while off
    offer(make_event(1'b1, 1'b0, 7'd0,   1'b0)); // initialise
    offer(make_event(1'b0, 1'b1, 7'd5,   1'b0)); // modem answers: power-down probe
    offer(make_event(1'b0, 1'b0, 7'd5,   1'b0)); // reset: power pulse
    offer(make_event(1'b0, 1'b0, 7'd5,   1'b0)); // ready, no answer
    offer(make_event(1'b0, 1'b1, 7'd5,   1'b0));
    offer(make_event(1'b0, 1'b0, 7'd5,   1'b0)); // SIM check fails once
    offer(make_event(1'b0, 1'b1, 7'd5,   1'b0));
    offer(make_event(1'b0, 1'b1, 7'd5,   1'b0)); // baud
    offer(make_event(1'b0, 1'b1, 7'd5,   1'b0)); // mode
    offer(make_event(1'b0, 1'b0, 7'd5,   1'b0)); // wait for mode
    offer(make_event(1'b0, 1'b1, 7'd0,   1'b0)); // signal zero: bad
    offer(make_event(1'b0, 1'b1, 7'd99,  1'b0)); // signal unknown
    offer(make_event(1'b0, 1'b1, 7'd127, 1'b1)); // out of range
    offer(make_event(1'b0, 1'b1, 7'd98,  1'b0)); // good reading
    offer(make_event(1'b0, 1'b0, 7'd98,  1'b0)); // attach fails
    offer(make_event(1'b0, 1'b1, 7'd1,   1'b0));
    offer(make_event(1'b0, 1'b0, 7'd1,   1'b0)); // linked, broker not answering
    offer(make_event(1'b0, 1'b1, 7'd1,   1'b0));
    offer(make_event(1'b0, 1'b1, 7'd1,   1'b0)); // handshake
    offer(make_event(1'b0, 1'b0, 7'd1,   1'b1)); // first: publish info
    offer(make_event(1'b0, 1'b0, 7'd1,   1'b1)); // connected, flush
    offer(make_event(1'b0, 1'b1, 7'd1,   1'b0)); // connected, nothing to flush
    offer(make_event(1'b1, 1'b1, 7'd127, 1'b1)); // initialise with all bits set

    // Random phases, each under its own settings; the last runs without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_settings(phase_cfg[p]);
      if (p == NUM_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_EVENTS; i++) begin
        if (p == 1 && i == 40) hold_off_req = 1'b1;
        offer(random_event((p % 2 == 1) ? 85 : 65));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("cellular_modem_bringup_sequencer_unit_tb: clean");
    end else begin
      $display("cellular_modem_bringup_sequencer_unit_tb: errors");
    end
    $finish;
  end

endmodule
